/* hw/rtl/glf_pkg.sv */
package glf_pkg;

  localparam int CFG_W  = 11;
  localparam int IDX_W  = 10;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CFG_W-1:0] RESET_SIZE = 11'd3;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic             restart;
  } cfg_t;

endpackage

/* hw/rtl/glf_if.sv */
interface glf_in_if #(
  parameter int MAG_BITS = 32
);
  logic                valid;
  logic                ready;
  logic [MAG_BITS-1:0] magnitude;
  logic                invalid;

  modport source (output valid, magnitude, invalid, input ready);
  modport sink (input valid, magnitude, invalid, output ready);
endinterface

interface glf_out_if;
  import glf_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;

  modport source (output valid, row_index, col_index, input ready);
  modport sink (input valid, row_index, col_index, output ready);
endinterface

/* hw/rtl/glf_cfg_regs.sv */
module glf_cfg_regs #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [glf_pkg::APB_AW-1:0] paddr,
  input  logic [glf_pkg::APB_DW-1:0] pwdata,
  output logic [glf_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output glf_pkg::cfg_t               cfg_o
);
  import glf_pkg::*;

  logic [CFG_W-1:0] rows_q, rows_d;
  logic [CFG_W-1:0] cols_q, cols_d;
  logic             wr_en;
  reg_idx_e         reg_idx;

  function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, int unsigned max_v);
    logic [CFG_W-1:0] res;
    begin
      if (v == '0) begin
        res = CFG_W'(1);
      end else if (32'(v) > max_v) begin
        res = CFG_W'(max_v);
      end else begin
        res = v;
      end
      return res;
    end
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (wr_en) begin
      case (reg_idx)
        REG_ROWS: rows_d = clamp_size(pwdata[CFG_W-1:0], MAX_ROWS);
        REG_COLS: cols_d = clamp_size(pwdata[CFG_W-1:0], MAX_COLS);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RESET_SIZE;
      cols_q <= RESET_SIZE;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROWS: prdata = APB_DW'(rows_q);
      REG_COLS: prdata = APB_DW'(cols_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.rows    = rows_q;
  assign cfg_o.cols    = cols_q;
  assign cfg_o.restart = wr_en;

endmodule

/* hw/rtl/glf_line_mem.sv */
module glf_line_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 66
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/glf_judge.sv */
module glf_judge #(
  parameter int MAG_BITS = 32
) (
  input  logic [MAG_BITS:0] center_i,
  input  logic [MAG_BITS:0] upper_i,
  input  logic [MAG_BITS:0] lower_i,
  input  logic [MAG_BITS:0] left_i,
  input  logic [MAG_BITS:0] right_i,
  input  logic              side_en_i,
  output logic              is_min_o
);

  function automatic logic less_than(logic [MAG_BITS:0] a, logic [MAG_BITS:0] b);
    return !a[MAG_BITS] && !b[MAG_BITS] && (a[MAG_BITS-1:0] < b[MAG_BITS-1:0]);
  endfunction

  logic vert_ok;
  logic side_ok;

  assign vert_ok  = less_than(center_i, upper_i) && less_than(center_i, lower_i);
  assign side_ok  = less_than(center_i, left_i) && less_than(center_i, right_i);
  assign is_min_o = vert_ok && (side_ok || !side_en_i);

endmodule

/* hw/rtl/grid_local_minimum_finder.sv */
// Channel | Direction | Payload                  | Handshake
// in_i    | sink      | magnitude, invalid       | valid / ready
// out_o   | source    | row_index, col_index     | valid / ready
// APB     | slave     | grid_rows @0, grid_cols @4 | psel / penable, pready tied high
//
// One request per cycle is taken while in_i is ready; its result is registered next cycle.
// The rate is set by the line memory: one read and one write per request, with the read
// running two columns ahead of the write so no port is shared within a column.
// The line memory has no clearing pass; a write to either register restarts the raster.
// The input is stalled only while a result waits in the output register and out_o is not ready.
module grid_local_minimum_finder #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  parameter int MAG_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  glf_in_if.sink                      in_i,
  glf_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [glf_pkg::APB_AW-1:0] paddr,
  input  logic [glf_pkg::APB_DW-1:0] pwdata,
  output logic [glf_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import glf_pkg::*;

  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int WORD_W = MAG_BITS + 1;
  localparam int CNT_W  = (RW > CW) ? RW : CW;
  localparam int CMP_W  = (CNT_W + 2 > CFG_W + 1) ? CNT_W + 2 : CFG_W + 1;

  typedef enum logic [1:0] {
    MODE_POINT,
    MODE_ROW,
    MODE_COL,
    MODE_GRID
  } mode_e;

  cfg_t                cfg;
  mode_e               mode;
  logic [RW-1:0]       r_q, r_d;
  logic [CW-1:0]       c_q, c_d;
  logic [CMP_W-1:0]    r_ext, c_ext, nr_ext, nc_ext, rd_sum, rd_wrap;
  logic                col_last, row_last;
  logic                accept;
  logic [WORD_W-1:0]   x;
  logic [WORD_W-1:0]   w0_q, w1_q;
  logic [2*WORD_W-1:0] cur_q;
  logic [2*WORD_W-1:0] rd_data;
  logic [WORD_W-1:0]   cen, up, right;
  logic [WORD_W-1:0]   j_center, j_upper;
  logic                side_en, is_min;
  logic                hit;
  logic [IDX_W-1:0]    hit_row, hit_col;
  logic                mem_en;
  logic                out_valid_q;
  logic [IDX_W-1:0]    out_row_q, out_col_q;

  glf_cfg_regs #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  always_comb begin
    if (cfg.rows == CFG_W'(1) && cfg.cols == CFG_W'(1)) begin
      mode = MODE_POINT;
    end else if (cfg.rows == CFG_W'(1)) begin
      mode = MODE_ROW;
    end else if (cfg.cols == CFG_W'(1)) begin
      mode = MODE_COL;
    end else begin
      mode = MODE_GRID;
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign x          = {in_i.invalid, in_i.magnitude};

  assign r_ext    = CMP_W'(r_q);
  assign c_ext    = CMP_W'(c_q);
  assign nr_ext   = CMP_W'(cfg.rows);
  assign nc_ext   = CMP_W'(cfg.cols);
  assign col_last = (c_ext + CMP_W'(1)) >= nc_ext;
  assign row_last = (r_ext + CMP_W'(1)) >= nr_ext;
  assign rd_sum   = c_ext + CMP_W'(2);
  assign rd_wrap  = (rd_sum >= nc_ext) ? (rd_sum - nc_ext) : rd_sum;

  // Each line word holds the upper row in its high half and the center row in its low half.
  assign mem_en = accept && (mode == MODE_GRID);
  assign cen    = cur_q[WORD_W-1:0];
  assign up     = cur_q[2*WORD_W-1:WORD_W];
  assign right  = rd_data[WORD_W-1:0];

  glf_line_mem #(
    .DEPTH(MAX_COLS),
    .WIDTH(2 * WORD_W)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (mem_en),
    .wr_addr_i(c_q),
    .wr_data_i({cen, x}),
    .rd_en_i  (mem_en),
    .rd_addr_i(rd_wrap[CW-1:0]),
    .rd_data_o(rd_data)
  );

  assign j_center = (mode == MODE_GRID) ? cen : w1_q;
  assign j_upper  = (mode == MODE_GRID) ? up : w0_q;
  assign side_en  = (mode == MODE_GRID);

  glf_judge #(
    .MAG_BITS(MAG_BITS)
  ) u_judge (
    .center_i (j_center),
    .upper_i  (j_upper),
    .lower_i  (x),
    .left_i   (w1_q),
    .right_i  (right),
    .side_en_i(side_en),
    .is_min_o (is_min)
  );

  always_comb begin
    hit     = 1'b0;
    hit_row = '0;
    hit_col = '0;
    case (mode)
      MODE_POINT: begin
        hit = 1'b1;
      end
      MODE_ROW: begin
        hit     = (c_ext >= CMP_W'(2)) && is_min;
        hit_col = IDX_W'(c_ext - CMP_W'(1));
      end
      MODE_COL: begin
        hit     = (r_ext >= CMP_W'(2)) && is_min;
        hit_row = IDX_W'(r_ext - CMP_W'(1));
      end
      MODE_GRID: begin
        hit     = (r_ext >= CMP_W'(2)) && (c_ext >= CMP_W'(1)) &&
                  ((c_ext + CMP_W'(2)) <= nc_ext) && is_min;
        hit_row = IDX_W'(r_ext - CMP_W'(1));
        hit_col = IDX_W'(c_ext);
      end
      default: ;
    endcase
  end

  always_comb begin
    r_d = r_q;
    c_d = c_q;
    if (cfg.restart) begin
      r_d = '0;
      c_d = '0;
    end else if (accept) begin
      if (col_last) begin
        c_d = '0;
        r_d = row_last ? '0 : r_q + RW'(1);
      end else begin
        c_d = c_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q         <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      r_q <= r_d;
      c_q <= c_d;
      if (accept) begin
        out_valid_q <= hit;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_row_q <= hit_row;
      out_col_q <= hit_col;
      if (mode == MODE_GRID) begin
        w1_q  <= cen;
        cur_q <= rd_data;
      end else begin
        w0_q <= w1_q;
        w1_q <= x;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.row_index = out_row_q;
  assign out_o.col_index = out_col_q;

endmodule

/* hw/rtl/glf_checker.sv */
module glf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [glf_pkg::IDX_W-1:0] out_row_i,
  input logic [glf_pkg::IDX_W-1:0] out_col_i
);
  import glf_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result request dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_row_i) && $stable(out_col_i))
    else $error("Result payload changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("Result appeared without a preceding input request.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("Input stalled while the output side could move.");

endmodule

bind grid_local_minimum_finder glf_checker u_glf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_row_i  (out_o.row_index),
  .out_col_i  (out_o.col_index)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import glf_pkg::*;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;
  localparam int MAG_BITS = 32;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } min_loc_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  glf_in_if #(.MAG_BITS(MAG_BITS)) in_bus ();
  glf_out_if out_bus ();

  grid_local_minimum_finder #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .MAG_BITS(MAG_BITS)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_bus),
    .out_o(out_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  bit [MAG_BITS:0] upper_mem [MAX_COLS];
  bit [MAG_BITS:0] center_mem [MAX_COLS];
  bit [MAG_BITS:0] left_prev [2];
  int unsigned pos_row = 0;
  int unsigned pos_col = 0;
  int unsigned n_rows = RESET_SIZE;
  int unsigned n_cols = RESET_SIZE;
  min_loc_t expected_minima [$];
  min_loc_t checked_loc;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;

  function automatic bit is_below(bit [MAG_BITS:0] a, bit [MAG_BITS:0] b);
    return !a[MAG_BITS] && !b[MAG_BITS] && (a[MAG_BITS-1:0] < b[MAG_BITS-1:0]);
  endfunction

  function automatic void note_minimum(int unsigned r, int unsigned c);
    min_loc_t loc;
    loc.row = IDX_W'(r);
    loc.col = IDX_W'(c);
    expected_minima = {expected_minima, loc};
  endfunction

  function automatic void track_sample(logic [MAG_BITS-1:0] mag, logic inv);
    bit [MAG_BITS:0] word;
    bit [MAG_BITS:0] cen;
    bit [MAG_BITS:0] right;
    int unsigned r;
    int unsigned c;
    word = {inv, mag};
    r = pos_row;
    c = pos_col;
    if (n_rows == 1 && n_cols == 1) begin
      note_minimum(0, 0);
    end else if (n_rows == 1) begin
      if (c >= 2 && is_below(left_prev[1], left_prev[0]) && is_below(left_prev[1], word)) begin
        note_minimum(0, c - 1);
      end
      left_prev[0] = left_prev[1];
      left_prev[1] = word;
    end else if (n_cols == 1) begin
      if (r >= 2 && is_below(center_mem[0], upper_mem[0]) && is_below(center_mem[0], word)) begin
        note_minimum(r - 1, 0);
      end
      upper_mem[0] = center_mem[0];
      center_mem[0] = word;
    end else begin
      cen = center_mem[c];
      if (r >= 2 && c >= 1 && c + 2 <= n_cols) begin
        right = center_mem[c + 1];
        if (is_below(cen, upper_mem[c]) && is_below(cen, word) &&
            is_below(cen, left_prev[0]) && is_below(cen, right)) begin
          note_minimum(r - 1, c);
        end
      end
      left_prev[0] = cen;
      upper_mem[c] = cen;
      center_mem[c] = word;
    end
    c++;
    if (c >= n_cols) begin
      c = 0;
      r++;
      if (r >= n_rows) begin
        r = 0;
      end
    end
    pos_row = r;
    pos_col = c;
  endfunction

  function automatic logic [MAG_BITS-1:0] random_magnitude();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return MAG_BITS'($urandom_range(15));
    if (pick < 85) return MAG_BITS'($urandom());
    if (pick < 92) return '0;
    return {{(MAG_BITS-4){1'b1}}, 4'($urandom_range(15))};
  endfunction

  function automatic logic random_invalid();
    return $urandom_range(7) == 0;
  endfunction

  function automatic logic [CFG_W-1:0] random_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 12) return '1;
    if (pick < 30) return CFG_W'(1);
    return CFG_W'($urandom_range(8, 2));
  endfunction

  task automatic send_sample(logic [MAG_BITS-1:0] mag, logic inv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.magnitude <= mag;
    in_bus.invalid <= inv;
    do @(posedge clk_i); while (!in_bus.ready);
    track_sample(mag, inv);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_sample(random_magnitude(), random_invalid());
  endtask

  task automatic wait_results_done();
    int unsigned waited;
    waited = 0;
    in_bus.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (expected_minima.size() != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_minima.size() != 0) begin
      $error("%0d expected minima never arrived", expected_minima.size());
      mismatch_count++;
      expected_minima.delete();
    end
  endtask

  task automatic write_size(reg_idx_e which, logic [CFG_W-1:0] value);
    int unsigned limit;
    int unsigned size;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= {(APB_DW-CFG_W)'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit = (which == REG_ROWS) ? MAX_ROWS : MAX_COLS;
    size = (value == 0) ? 1 : ((value > limit) ? limit : value);
    if (which == REG_ROWS) begin
      n_rows = size;
    end else begin
      n_cols = size;
    end
    pos_row = 0;
    pos_col = 0;
    left_prev[0] = '0;
    left_prev[1] = '0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_size();
    for (int i = 0; i < 9; i++) begin
      send_sample((i == 4) ? '0 : '1, 1'b0);
    end
    // An invalid left neighbor blocks the center point.
    for (int i = 0; i < 9; i++) begin
      send_sample((i == 4) ? MAG_BITS'(1) : MAG_BITS'(5), i == 3);
    end
    wait_results_done();
  endtask

  task automatic test_grid_shapes();
    logic [MAG_BITS-1:0] row_vals [5];
    logic [MAG_BITS-1:0] col_vals [5];
    row_vals = '{7, 2, 7, 0, 9};
    col_vals = '{5, 3, 5, 1, 5};
    write_size(REG_ROWS, CFG_W'(1));
    write_size(REG_COLS, CFG_W'(1));
    send_random(3);
    wait_results_done();
    write_size(REG_COLS, CFG_W'(5));
    for (int i = 0; i < 5; i++) begin
      send_sample(row_vals[i], i == 3);
    end
    wait_results_done();
    write_size(REG_ROWS, CFG_W'(5));
    write_size(REG_COLS, '0);
    for (int i = 0; i < 5; i++) begin
      send_sample(col_vals[i], 1'b0);
    end
    wait_results_done();
    write_size(REG_ROWS, '1);
    send_random(40);
    wait_results_done();
    write_size(REG_ROWS, CFG_W'(1));
    write_size(REG_COLS, CFG_W'(MAX_COLS));
    send_random(40);
    wait_results_done();
  endtask

  task automatic test_wide_grid();
    send_idle_pct = 11;
    stall_pct = 11;
    write_size(REG_ROWS, CFG_W'(3));
    write_size(REG_COLS, CFG_W'(96));
    send_random(3 * 96);
    wait_results_done();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    write_size(REG_ROWS, CFG_W'(1));
    write_size(REG_COLS, CFG_W'(1));
    hold_cycles = 300;
    send_random(40);
    wait_results_done();
    send_random(20);
    wait_results_done();
  endtask

  task automatic test_random_phases();
    int unsigned idle_by_phase [4];
    int unsigned stall_by_phase [4];
    idle_by_phase = '{0, 84, 0, 11};
    stall_by_phase = '{0, 0, 84, 11};
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      repeat (2) begin
        write_size(REG_ROWS, random_size());
        write_size(REG_COLS, random_size());
        send_random(45);
        wait_results_done();
      end
    end
  endtask

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_minima.size() == 0) begin
        $error("unexpected result row_index=%0d col_index=%0d",
               out_bus.row_index, out_bus.col_index);
        mismatch_count++;
      end else begin
        checked_loc = expected_minima.pop_front();
        if (out_bus.row_index !== checked_loc.row) begin
          $error("row_index mismatch: expected %0d, actual %0d",
                 checked_loc.row, out_bus.row_index);
          mismatch_count++;
        end
        if (out_bus.col_index !== checked_loc.col) begin
          $error("col_index mismatch: expected %0d, actual %0d",
                 checked_loc.col, out_bus.col_index);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_bus.valid <= 1'b0;
    in_bus.magnitude <= '0;
    in_bus.invalid <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_grid_shapes();
    test_wide_grid();
    test_backpressure();
    test_random_phases();
    stall_pct = 0;
    wait_results_done();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
